@@ design/satlb_pkg.sv @@
package satlb_pkg;

    localparam int VPAGE_W = 20;
    localparam int PPAGE_W = 20;
    localparam int STAMP_W = 32;

    // SETS is a power of two, so set and tag are a mask and a shift of the page
    localparam int SETS    = 16;
    localparam int WAYS    = 4;
    localparam int SET_AW  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_AW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W   = VPAGE_W - ((SETS > 1) ? $clog2(SETS) : 0);

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic               dirty;
        logic [TAG_W-1:0]   tag;
        logic [PPAGE_W-1:0] ppage;
        logic [STAMP_W-1:0] stamp;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

endpackage

@@ design/satlb_ram.sv @@
module satlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

@@ design/set_assoc_tlb_lru_dirty_core.sv @@
// set-associative tlb with lru replacement and dirty tracking
//
// a word is offered on start with func, is_write, vpage, new_ppage, new_dirty
// and stamp, and is taken at the clock edge where start is high and busy is low.
// a lookup (func 0) returns one result word; an insert (func 1) returns none.
// the result appears on o_hit, o_ppage and o_dirty_newly_set for exactly one
// cycle, marked by o_valid; the receiver cannot stall it, so it must take it.
//
// timing: the set row is read from the way memory at the accepting edge, the
// following cycle compares the ways, picks the victim and writes the row back
// (busy is high in that cycle), and the result is registered at its end.
// a lookup result is therefore held in the output registers and is on the
// ports after the edge that ends the update cycle. no new word is taken while
// busy is high, during the one read-modify-write of the row memory;
// the write lands before the next read, so no forwarding is needed.
//
// reset (i_rst_n low, synchronous) clears all valid bits at once and returns
// the block to idle; the row memory itself is not cleared, since invalid ways
// are never used as hits.
module set_assoc_tlb_lru_dirty_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic                          i_is_write,
    input  logic [satlb_pkg::VPAGE_W-1:0] i_vpage,
    input  logic [satlb_pkg::PPAGE_W-1:0] i_new_ppage,
    input  logic                          i_new_dirty,
    input  logic [satlb_pkg::STAMP_W-1:0] i_stamp,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic [satlb_pkg::PPAGE_W-1:0] o_ppage,
    output logic                          o_dirty_newly_set
);

    satlb_pkg::t_state r_state, n_state;

    logic                          r_func;
    logic                          r_is_write;
    logic [satlb_pkg::SET_AW-1:0]  r_set;
    logic [satlb_pkg::TAG_W-1:0]   r_tag;
    logic [satlb_pkg::PPAGE_W-1:0] r_new_ppage;
    logic                          r_new_dirty;
    logic [satlb_pkg::STAMP_W-1:0] r_stamp;

    logic [satlb_pkg::WAYS-1:0]    r_valid [satlb_pkg::SETS];

    logic                          r_out_valid;
    logic                          r_out_hit;
    logic [satlb_pkg::PPAGE_W-1:0] r_out_ppage;
    logic                          r_out_newly;

    logic                          accept;
    logic                          in_update;
    logic [satlb_pkg::SET_AW-1:0]  in_set;
    logic [satlb_pkg::ROW_W-1:0]   rd_data;
    satlb_pkg::t_row               row;
    satlb_pkg::t_row               new_row;
    logic [satlb_pkg::WAYS-1:0]    set_valid;
    logic                          hit;
    logic [satlb_pkg::WAY_AW-1:0]  hit_way;
    logic                          has_free;
    logic [satlb_pkg::WAY_AW-1:0]  free_way;
    logic [satlb_pkg::WAY_AW-1:0]  lru_way;
    logic [satlb_pkg::STAMP_W-1:0] least;
    logic [satlb_pkg::WAY_AW-1:0]  victim;
    logic                          newly;
    logic                          wr_en;

    assign accept    = start && !busy;
    assign in_update = (r_state == satlb_pkg::ST_UPDATE);
    assign in_set    = satlb_pkg::SET_AW'(i_vpage % satlb_pkg::SETS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= satlb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b0;
        case (r_state)
            satlb_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = satlb_pkg::ST_UPDATE;
                end
            end
            satlb_pkg::ST_UPDATE: begin
                busy    = 1'b1;
                n_state = satlb_pkg::ST_IDLE;
            end
            default: begin
                n_state = satlb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func      <= i_func;
            r_is_write  <= i_is_write;
            r_set       <= in_set;
            r_tag       <= satlb_pkg::TAG_W'(i_vpage / satlb_pkg::SETS);
            r_new_ppage <= i_new_ppage;
            r_new_dirty <= i_new_dirty;
            r_stamp     <= i_stamp;
        end
    end

    satlb_ram #(
        .WIDTH (satlb_pkg::ROW_W),
        .DEPTH (satlb_pkg::SETS)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_set),
        .i_wr_data (new_row),
        .i_rd_en   (accept),
        .i_rd_addr (in_set),
        .o_rd_data (rd_data)
    );

    assign row       = satlb_pkg::t_row'(rd_data);
    assign set_valid = r_valid[r_set];

    // first valid matching way wins
    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < satlb_pkg::WAYS; w++) begin
            if (!hit && set_valid[w] && row[w].tag == r_tag) begin
                hit     = 1'b1;
                hit_way = satlb_pkg::WAY_AW'(w);
            end
        end
    end

    // victim: first free way, else least stamp with the lowest way on ties
    always_comb begin
        has_free = 1'b0;
        free_way = '0;
        lru_way  = '0;
        least    = row[0].stamp;
        for (int w = 0; w < satlb_pkg::WAYS; w++) begin
            if (!has_free && !set_valid[w]) begin
                has_free = 1'b1;
                free_way = satlb_pkg::WAY_AW'(w);
            end
        end
        for (int w = 1; w < satlb_pkg::WAYS; w++) begin
            if (row[w].stamp < least) begin
                least   = row[w].stamp;
                lru_way = satlb_pkg::WAY_AW'(w);
            end
        end
        victim = has_free ? free_way : lru_way;
    end

    always_comb begin
        new_row = row;
        newly   = 1'b0;
        wr_en   = 1'b0;
        if (in_update) begin
            if (r_func == satlb_pkg::FUNC_INSERT) begin
                wr_en                 = 1'b1;
                new_row[victim].dirty = r_is_write | r_new_dirty;
                new_row[victim].tag   = r_tag;
                new_row[victim].ppage = r_new_ppage;
                new_row[victim].stamp = r_stamp;
            end else if (hit) begin
                wr_en                  = 1'b1;
                newly                  = r_is_write && !row[hit_way].dirty;
                new_row[hit_way].stamp = r_stamp;
                if (r_is_write) begin
                    new_row[hit_way].dirty = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < satlb_pkg::SETS; s++) begin
                r_valid[s] <= '0;
            end
        end else if (in_update && r_func == satlb_pkg::FUNC_INSERT) begin
            r_valid[r_set][victim] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= in_update && r_func == satlb_pkg::FUNC_LOOKUP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_update) begin
            r_out_hit   <= hit;
            r_out_ppage <= hit ? row[hit_way].ppage : '1;
            r_out_newly <= newly;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_hit             = r_out_hit;
    assign o_ppage           = r_out_ppage;
    assign o_dirty_newly_set = r_out_newly;

    // each accepted word is followed by its read-modify-write in the next cycle
    a_update_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("no update cycle after an accepted word");

    a_single_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("update cycle lasted more than one cycle");

    a_result_follows_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result word without a preceding update");

    a_miss_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_ppage == '1 && !o_dirty_newly_set))
        else $error("miss word carries a page or a dirty flag");

    a_write_port_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (busy && !accept))
        else $error("row written outside the update cycle");

endmodule
